### src/thermistor_window_linearizer_core_defines.svh
// Assertion macros shared by the thermistor window linearizer RTL.
// Each macro expands to nothing when NO_ASSERTIONS is defined.
`ifndef THERMISTOR_WINDOW_LINEARIZER_CORE_DEFINES_SVH
`define THERMISTOR_WINDOW_LINEARIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold on every clock edge outside reset.
`define TWL_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("twl assertion failed");

// Antecedent in a cycle implies consequent in the next.
`define TWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twl assertion failed");

`else

`define TWL_ASSERT(label, expr)
`define TWL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/twl_pkg.sv
// Types, codes and the ADC-to-temperature table of the thermistor window linearizer.
// No dependencies; used by twl_div and thermistor_window_linearizer_core.
`timescale 1ns / 1ps
`default_nettype none

package twl_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TEMP_W     = 11;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam int TABLE_POINTS = 17;
    localparam int TBL_IDX_W    = $clog2(TABLE_POINTS);

    localparam logic [SAMPLE_W-1:0] ADC_POINTS [TABLE_POINTS] = '{
        12'd738,  12'd895,  12'd1068, 12'd1256, 12'd1455, 12'd1659,
        12'd1866, 12'd2070, 12'd2268, 12'd2457, 12'd2635, 12'd2799,
        12'd2948, 12'd3084, 12'd3206, 12'd3314, 12'd3410
    };

    localparam logic signed [TEMP_W-1:0] TEMP_POINTS [TABLE_POINTS] = '{
        -11'sd200, -11'sd150, -11'sd100, -11'sd50, 11'sd0,   11'sd50,
        11'sd100,  11'sd150,  11'sd200,  11'sd250, 11'sd300, 11'sd350,
        11'sd400,  11'sd450,  11'sd500,  11'sd550, 11'sd600
    };

    // The widest segment of the table spans 207 ADC codes and 50 tenths,
    // so the offset inside a segment fits 8 bits and the step fits 6 bits.
    localparam int SEG_DX_W = 8;
    localparam int SEG_DT_W = 6;
    localparam int NUM_W    = SEG_DX_W + SEG_DT_W;

    localparam logic signed [TEMP_W-1:0] FALLBACK_RESET = 11'sd200;

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     in_range;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

### src/twl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on twl_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module twl_div #(
    parameter int N = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [N-1:0]      i_dividend,
    input  wire logic [N-1:0]      i_divisor,
    output twl_pkg::t_div_status   o_status,
    output logic      [N-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     r_rem;
    logic [N-1:0]     r_quo;
    logic [N-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [N:0]       trial;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try the divisor.
    assign trial = {r_rem, r_quo[N-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start && (r_cnt == '0)) begin
                r_cnt <= CNT_W'(N);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && (r_cnt == '0)) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? N'(trial - {1'b0, r_dvs}) : trial[N-1:0];
            r_quo <= {r_quo[N-2:0], fits};
        end
    end

    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

`default_nettype wire

### src/thermistor_window_linearizer_core.sv
// Top level of the thermistor window linearizer: sample window, sequencer and output register.
// Depends on twl_pkg, twl_div and thermistor_window_linearizer_core_defines.svh.
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ----------------------------------
//  in       input      i_in_valid / o_in_stall   i_in_data  (operation, sample)
//  out      output     o_out_valid / i_out_stall o_out_data (temperature, in_range)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (fallback_temperature)
//
// A push transaction leaves the sequencer idle, so the input stays ready for more items.
// A read transaction stalls the input through its steps: window reads through the single
// read port, the mean, the range check, the segment search through one compare, the setup
// of the interpolation, the division in the one-bit-per-cycle divider and the load of the
// output register.
// A mean outside the table skips the search and the division.
// Reset is synchronous and active low; it clears the window valid bits, so that
// unwritten entries read as zero, and sets the fallback register to 200.
// A result waits in the output register while i_out_stall is high; new pushes are taken
// meanwhile, and a finished read holds in its last step until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "thermistor_window_linearizer_core_defines.svh"

module thermistor_window_linearizer_core #(
    parameter int WINDOW_SIZE = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire twl_pkg::t_in_item    i_in_data,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output twl_pkg::t_out_item        o_out_data,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [twl_pkg::TEMP_W-1:0] i_cfg_data
);

    localparam int SUM_W = $clog2(4095 * WINDOW_SIZE + 1);
    localparam int IDX_W = $clog2(WINDOW_SIZE + 1);
    localparam int AW    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int DIV_W = twl_pkg::NUM_W;
    localparam int SW    = twl_pkg::SAMPLE_W;
    localparam int TW    = twl_pkg::TEMP_W;
    localparam int TIW   = twl_pkg::TBL_IDX_W;

    // The mean is taken by a reciprocal multiplication. RECIP is 2^MEAN_K / WINDOW_SIZE
    // rounded up; its rounding error times the largest sum stays below 2^MEAN_K, so the
    // product shifted down by MEAN_K is exactly the truncated quotient.
    localparam int MEAN_K  = SUM_W + 6;
    localparam int RECIP_W = MEAN_K + 1;
    localparam int RECIP   = ((1 << MEAN_K) + WINDOW_SIZE - 1) / WINDOW_SIZE;
    localparam int MP_W    = SUM_W + RECIP_W;

    // Sequencer codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_MEAN   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_SEARCH = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_INT    = 4'd7;
    localparam logic [3:0] S_IWAIT  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]              r_state;
    logic [3:0]              n_state;

    // Sample window: a memory with one write and one read port, plus valid bits.
    logic [SW-1:0]           r_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0]  r_valid;
    logic [AW-1:0]           r_wr_pos;
    logic [SW-1:0]           r_rd_data;
    logic                    r_rd_ok;
    logic                    r_rd_pend;

    logic [IDX_W-1:0]        r_idx;
    logic [SUM_W-1:0]        r_acc;
    logic [SW-1:0]           r_mean;
    logic [TIW-1:0]          r_seg;
    logic [twl_pkg::NUM_W-1:0] r_prod;
    logic [TW-1:0]           r_temp;
    logic                    r_ok;
    logic [TW-1:0]           r_fallback;

    logic                    r_out_valid;
    twl_pkg::t_out_item      r_out_data;

    logic                    in_acc;
    logic                    read_acc;
    logic                    rd_issue;
    logic [AW-1:0]           rd_addr;
    logic [MP_W-1:0]         mean_prod;
    logic                    mean_in_table;
    logic [TIW-1:0]          seg_next;
    logic [SW-1:0]           seg_dx;
    logic [TW-1:0]           seg_dt;
    logic [SW-1:0]           seg_den;
    logic                    out_free;

    logic                    div_start;
    logic [DIV_W-1:0]        div_dividend;
    logic [DIV_W-1:0]        div_divisor;
    twl_pkg::t_div_status    div_status;
    logic [DIV_W-1:0]        div_quotient;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign read_acc    = in_acc && (i_in_data.operation == twl_pkg::OP_READ);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign rd_issue = (r_state == S_SUM) && (r_idx != IDX_W'(WINDOW_SIZE));
    assign rd_addr  = r_idx[AW-1:0];

    assign mean_prod     = MP_W'(r_acc) * MP_W'(RECIP);
    assign mean_in_table = (r_mean >= twl_pkg::ADC_POINTS[0]) &&
                           (r_mean < twl_pkg::ADC_POINTS[twl_pkg::TABLE_POINTS-1]);

    assign seg_next = TIW'(r_seg + TIW'(1));
    assign seg_dx   = r_mean - twl_pkg::ADC_POINTS[r_seg];
    assign seg_dt   = twl_pkg::TEMP_POINTS[seg_next] - twl_pkg::TEMP_POINTS[r_seg];
    assign seg_den  = twl_pkg::ADC_POINTS[seg_next] - twl_pkg::ADC_POINTS[r_seg];

    // The divider serves the segment interpolation.
    assign div_start    = (r_state == S_INT);
    assign div_dividend = r_prod;
    assign div_divisor  = DIV_W'(seg_den);

    twl_div #(
        .N (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_status),
        .o_quotient (div_quotient)
    );

    // Window memory: written by push transactions, read once per entry during a sum.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.operation == twl_pkg::OP_PUSH)) begin
            r_mem[r_wr_pos] <= i_in_data.sample;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_valid[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (read_acc) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (!rd_issue) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN:   n_state = S_CHECK;
            S_CHECK: begin
                if (mean_in_table) begin
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SEARCH: begin
                if (r_mean < twl_pkg::ADC_POINTS[seg_next]) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_INT;
            S_INT:    n_state = S_IWAIT;
            S_IWAIT: begin
                if (div_status.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_wr_pos    <= '0;
            r_rd_pend   <= 1'b0;
            r_fallback  <= twl_pkg::FALLBACK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fallback <= i_cfg_data;
            end
            if (in_acc && (i_in_data.operation == twl_pkg::OP_PUSH)) begin
                r_valid[r_wr_pos] <= 1'b1;
                if (r_wr_pos == AW'(WINDOW_SIZE - 1)) begin
                    r_wr_pos <= '0;
                end else begin
                    r_wr_pos <= r_wr_pos + AW'(1);
                end
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx <= '0;
                r_acc <= '0;
            end
            S_SUM: begin
                if (rd_issue) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (r_rd_pend && r_rd_ok) begin
                    r_acc <= r_acc + SUM_W'(r_rd_data);
                end
            end
            S_MEAN: begin
                r_mean <= mean_prod[MEAN_K +: SW];
            end
            S_CHECK: begin
                r_seg  <= '0;
                r_temp <= r_fallback;
                r_ok   <= 1'b0;
            end
            S_SEARCH: begin
                if (!(r_mean < twl_pkg::ADC_POINTS[seg_next])) begin
                    r_seg <= seg_next;
                end
            end
            S_MUL: begin
                r_prod <= twl_pkg::NUM_W'(seg_dx[twl_pkg::SEG_DX_W-1:0]) *
                          twl_pkg::NUM_W'(seg_dt[twl_pkg::SEG_DT_W-1:0]);
            end
            S_IWAIT: begin
                if (div_status.done) begin
                    r_temp <= div_quotient[TW-1:0] + twl_pkg::TEMP_POINTS[r_seg];
                    r_ok   <= 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data.temperature <= r_temp;
                    r_out_data.in_range    <= r_ok;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A read transaction always begins with the window sum.
    `TWL_ASSERT_NEXT(a_read_starts_sum, read_acc, r_state == S_SUM)
    // The divider is only started once the previous division has finished.
    `TWL_ASSERT(a_div_start_idle, !div_start || !div_status.busy)
    // A division completes only while the sequencer waits for it.
    `TWL_ASSERT(a_div_done_waited, !div_status.done || (r_state == S_IWAIT))
    // The segment search runs only on a mean that lies inside the table.
    `TWL_ASSERT(a_search_in_table, (r_state != S_SEARCH) || mean_in_table)

endmodule

`default_nettype wire
